@@ rtl/lpfr_pkg.sv @@
package lpfr_pkg;

  localparam int PANEL_ROWS   = 2;
  localparam int PANEL_COLS   = 12;
  localparam int QUARTER_ROWS = 2;
  localparam int QUARTER_COLS = 2;
  localparam int PIXEL_ROWS   = 8;
  localparam int GRAY_BYTES   = 4;

  localparam int HALF_COLS     = PANEL_COLS / 2;
  localparam int STRETCH_DEPTH = PANEL_ROWS * PANEL_COLS * QUARTER_ROWS * QUARTER_COLS;
  localparam int PIXEL_DEPTH   = STRETCH_DEPTH * PIXEL_ROWS * GRAY_BYTES;

  // quarter block lengths and pass lengths, grayscale and binary rows
  localparam int LD_QBLK_G = 1 + PANEL_COLS + PIXEL_ROWS * GRAY_BYTES * PANEL_COLS;
  localparam int LD_QBLK_B = 1 + PANEL_COLS + PIXEL_ROWS * PANEL_COLS;
  localparam int LD_LEN_G  = PANEL_ROWS * QUARTER_COLS * QUARTER_ROWS * LD_QBLK_G;
  localparam int LD_LEN_B  = PANEL_ROWS * QUARTER_COLS * QUARTER_ROWS * LD_QBLK_B;
  localparam int RD_BLKS   = HALF_COLS * PANEL_ROWS * 2 * QUARTER_COLS * QUARTER_ROWS;
  localparam int RD_LEN_G  = RD_BLKS * (1 + PIXEL_ROWS * GRAY_BYTES);
  localparam int RD_LEN_B  = RD_BLKS * (1 + PIXEL_ROWS);
  localparam int LEN_MAX   = (LD_LEN_G > RD_LEN_G) ? LD_LEN_G : RD_LEN_G;

  function automatic int cnt_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  localparam int POS_W  = $clog2(LEN_MAX + 1);
  localparam int ROW_W  = cnt_w(PANEL_ROWS);
  localparam int COL_W  = cnt_w(PANEL_COLS);
  localparam int QR_W   = cnt_w(QUARTER_ROWS);
  localparam int QC_W   = cnt_w(QUARTER_COLS);
  localparam int PXR_W  = cnt_w(PIXEL_ROWS);
  localparam int GB_W   = cnt_w(GRAY_BYTES);
  localparam int HC_W   = cnt_w(HALF_COLS);
  localparam int SA_W   = cnt_w(STRETCH_DEPTH);
  localparam int PA_W   = cnt_w(PIXEL_DEPTH);

  localparam int POSITION_W = 12;

  typedef struct packed {
    logic       cmd;
    logic [7:0] pattern_byte;
  } lpfr_in_t;

  typedef struct packed {
    logic [7:0]            out_byte;
    logic [POSITION_W-1:0] pass_position;
    logic                  pass_last;
  } lpfr_out_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic ld_clr;
    logic ld_walk;
    logic ld_sync;
    logic rd_clr;
    logic rd_walk;
    logic rd_sync;
  } lpfr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ld_stale;
    logic rd_stale;
    logic ld_walk_done;
    logic rd_walk_done;
  } lpfr_stat_t;

endpackage

@@ rtl/lpfr_ctrl.sv @@
module lpfr_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  lpfr_pkg::lpfr_stat_t   stat,
  output lpfr_pkg::lpfr_cmd_t    cmd
);
  import lpfr_pkg::*;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_LD_CLR  = 3'd1;
  localparam logic [2:0] ST_LD_WALK = 3'd2;
  localparam logic [2:0] ST_RD_CLR  = 3'd3;
  localparam logic [2:0] ST_RD_WALK = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign busy = (state_r != ST_IDLE) || stat.ld_stale || stat.rd_stale;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (stat.ld_stale) begin
          state_nxt = ST_LD_CLR;
        end else if (stat.rd_stale) begin
          state_nxt = ST_RD_CLR;
        end else begin
          cmd.accept = start;
        end
      end
      ST_LD_CLR: begin
        cmd.ld_clr = 1'b1;
        state_nxt  = ST_LD_WALK;
      end
      ST_LD_WALK: begin
        // count the digit counters up to the saved position under the new mode
        if (stat.ld_walk_done) begin
          cmd.ld_sync = 1'b1;
          state_nxt   = ST_IDLE;
        end else begin
          cmd.ld_walk = 1'b1;
        end
      end
      ST_RD_CLR: begin
        cmd.rd_clr = 1'b1;
        state_nxt  = ST_RD_WALK;
      end
      ST_RD_WALK: begin
        if (stat.rd_walk_done) begin
          cmd.rd_sync = 1'b1;
          state_nxt   = ST_IDLE;
        end else begin
          cmd.rd_walk = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/lpfr_datapath.sv @@
module lpfr_datapath (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lpfr_pkg::lpfr_cmd_t    cmd,
  output lpfr_pkg::lpfr_stat_t   stat,
  input  lpfr_pkg::lpfr_in_t     in_data,
  input  logic                   cfg_we,
  input  logic                   cfg_wdata,
  output logic                   out_valid,
  output lpfr_pkg::lpfr_out_t    out_data
);
  import lpfr_pkg::*;

  localparam logic [1:0] PH_SIG = 2'd0;
  localparam logic [1:0] PH_STR = 2'd1;
  localparam logic [1:0] PH_PIX = 2'd2;

  logic             gray_r, ld_mode_r, rd_mode_r;
  logic [POS_W-1:0] ld_pos_r, rd_pos_r, walk_r;

  // load pass digits
  logic [1:0]       ld_ph_r;
  logic [COL_W-1:0] ld_col_r;
  logic [GB_W-1:0]  ld_b_r;
  logic [PXR_W-1:0] ld_prc_r;
  logic [QR_W-1:0]  ld_qrc_r;
  logic [QC_W-1:0]  ld_qc_r;
  logic [ROW_W-1:0] ld_rowc_r;

  // readout pass digits
  logic             rd_pix_r;
  logic [GB_W-1:0]  rd_b_r;
  logic [PXR_W-1:0] rd_pr_r;
  logic [QR_W-1:0]  rd_qr_r;
  logic [QC_W-1:0]  rd_qc_r;
  logic             rd_reg_r;
  logic [ROW_W-1:0] rd_row_r;
  logic [HC_W-1:0]  rd_rc_r;

  logic [1:0]       ld_ph_nxt;
  logic [COL_W-1:0] ld_col_nxt;
  logic [GB_W-1:0]  ld_b_nxt;
  logic [PXR_W-1:0] ld_prc_nxt;
  logic [QR_W-1:0]  ld_qrc_nxt;
  logic [QC_W-1:0]  ld_qc_nxt;
  logic [ROW_W-1:0] ld_rowc_nxt;
  logic             ld_blk_adv;

  logic             rd_pix_nxt;
  logic [GB_W-1:0]  rd_b_nxt;
  logic [PXR_W-1:0] rd_pr_nxt;
  logic [QR_W-1:0]  rd_qr_nxt;
  logic [QC_W-1:0]  rd_qc_nxt;
  logic             rd_reg_nxt;
  logic [ROW_W-1:0] rd_row_nxt;
  logic [HC_W-1:0]  rd_rc_nxt;
  logic             rd_blk_adv;

  logic [GB_W-1:0]  b_max;
  logic [POS_W-1:0] ld_len, rd_len, ld_pos_inc, rd_pos_inc;
  logic             ld_last, rd_last;

  logic [ROW_W-1:0] ld_row;
  logic [COL_W-1:0] ld_col;
  logic [QR_W-1:0]  ld_qr;
  logic [PXR_W-1:0] ld_pr;
  logic [SA_W-1:0]  ld_s, rd_s, str_addr;
  logic [PA_W-1:0]  ld_pa, rd_pa, pix_addr;
  logic [COL_W-1:0] rd_col;
  logic             str_we, pix_we;

  logic [7:0]       pix_mem [PIXEL_DEPTH];
  logic [7:0]       str_mem [STRETCH_DEPTH];
  logic [7:0]       pix_q_r, str_q_r;

  logic             out_valid_r, out_rd_r, out_str_r, out_last_r;
  logic [POS_W-1:0] out_pos_r;

  logic             ld_item, rd_item;

  assign ld_item = cmd.accept && !in_data.cmd;
  assign rd_item = cmd.accept && in_data.cmd;

  assign b_max  = gray_r ? GB_W'(GRAY_BYTES - 1) : '0;
  assign ld_len = gray_r ? POS_W'(LD_LEN_G) : POS_W'(LD_LEN_B);
  assign rd_len = gray_r ? POS_W'(RD_LEN_G) : POS_W'(RD_LEN_B);

  assign ld_pos_inc = ld_pos_r + POS_W'(1);
  assign rd_pos_inc = rd_pos_r + POS_W'(1);
  assign ld_last    = (ld_pos_inc == ld_len);
  assign rd_last    = (rd_pos_inc == rd_len);

  assign stat.ld_stale     = (ld_mode_r != gray_r);
  assign stat.rd_stale     = (rd_mode_r != gray_r);
  assign stat.ld_walk_done = (walk_r == ld_pos_r);
  assign stat.rd_walk_done = (walk_r == rd_pos_r);

  // load digit step: signifier, stretch columns, then pixel col/byte/row
  always_comb begin
    ld_ph_nxt   = ld_ph_r;
    ld_col_nxt  = ld_col_r;
    ld_b_nxt    = ld_b_r;
    ld_prc_nxt  = ld_prc_r;
    ld_qrc_nxt  = ld_qrc_r;
    ld_qc_nxt   = ld_qc_r;
    ld_rowc_nxt = ld_rowc_r;
    ld_blk_adv  = 1'b0;
    case (ld_ph_r)
      PH_SIG: begin
        ld_ph_nxt  = PH_STR;
        ld_col_nxt = '0;
      end
      PH_STR: begin
        if (ld_col_r == COL_W'(PANEL_COLS - 1)) begin
          ld_ph_nxt  = PH_PIX;
          ld_col_nxt = '0;
          ld_b_nxt   = '0;
          ld_prc_nxt = '0;
        end else begin
          ld_col_nxt = ld_col_r + COL_W'(1);
        end
      end
      PH_PIX: begin
        if (ld_col_r == COL_W'(PANEL_COLS - 1)) begin
          ld_col_nxt = '0;
          if (ld_b_r == b_max) begin
            ld_b_nxt = '0;
            if (ld_prc_r == PXR_W'(PIXEL_ROWS - 1)) begin
              ld_prc_nxt = '0;
              ld_ph_nxt  = PH_SIG;
              ld_blk_adv = 1'b1;
            end else begin
              ld_prc_nxt = ld_prc_r + PXR_W'(1);
            end
          end else begin
            ld_b_nxt = ld_b_r + GB_W'(1);
          end
        end else begin
          ld_col_nxt = ld_col_r + COL_W'(1);
        end
      end
      default: ld_ph_nxt = PH_SIG;
    endcase
    if (ld_blk_adv) begin
      if (ld_qrc_r == QR_W'(QUARTER_ROWS - 1)) begin
        ld_qrc_nxt = '0;
        if (ld_qc_r == QC_W'(QUARTER_COLS - 1)) begin
          ld_qc_nxt = '0;
          if (ld_rowc_r == ROW_W'(PANEL_ROWS - 1)) begin
            ld_rowc_nxt = '0;
          end else begin
            ld_rowc_nxt = ld_rowc_r + ROW_W'(1);
          end
        end else begin
          ld_qc_nxt = ld_qc_r + QC_W'(1);
        end
      end else begin
        ld_qrc_nxt = ld_qrc_r + QR_W'(1);
      end
    end
  end

  // readout digit step: stretch, then pixel byte/row, then block digits
  always_comb begin
    rd_pix_nxt = rd_pix_r;
    rd_b_nxt   = rd_b_r;
    rd_pr_nxt  = rd_pr_r;
    rd_qr_nxt  = rd_qr_r;
    rd_qc_nxt  = rd_qc_r;
    rd_reg_nxt = rd_reg_r;
    rd_row_nxt = rd_row_r;
    rd_rc_nxt  = rd_rc_r;
    rd_blk_adv = 1'b0;
    if (!rd_pix_r) begin
      rd_pix_nxt = 1'b1;
      rd_b_nxt   = '0;
      rd_pr_nxt  = '0;
    end else if (rd_b_r == b_max) begin
      rd_b_nxt = '0;
      if (rd_pr_r == PXR_W'(PIXEL_ROWS - 1)) begin
        rd_pr_nxt  = '0;
        rd_pix_nxt = 1'b0;
        rd_blk_adv = 1'b1;
      end else begin
        rd_pr_nxt = rd_pr_r + PXR_W'(1);
      end
    end else begin
      rd_b_nxt = rd_b_r + GB_W'(1);
    end
    if (rd_blk_adv) begin
      if (rd_qr_r == QR_W'(QUARTER_ROWS - 1)) begin
        rd_qr_nxt = '0;
        if (rd_qc_r == QC_W'(QUARTER_COLS - 1)) begin
          rd_qc_nxt = '0;
          if (rd_reg_r) begin
            rd_reg_nxt = 1'b0;
            if (rd_row_r == ROW_W'(PANEL_ROWS - 1)) begin
              rd_row_nxt = '0;
              if (rd_rc_r == HC_W'(HALF_COLS - 1)) begin
                rd_rc_nxt = '0;
              end else begin
                rd_rc_nxt = rd_rc_r + HC_W'(1);
              end
            end else begin
              rd_row_nxt = rd_row_r + ROW_W'(1);
            end
          end else begin
            rd_reg_nxt = 1'b1;
          end
        end else begin
          rd_qc_nxt = rd_qc_r + QC_W'(1);
        end
      end else begin
        rd_qr_nxt = rd_qr_r + QR_W'(1);
      end
    end
  end

  // store addresses; frame column c > 0 lands at column PANEL_COLS - c
  assign ld_row = ROW_W'(PANEL_ROWS - 1) - ld_rowc_r;
  assign ld_qr  = QR_W'(QUARTER_ROWS - 1) - ld_qrc_r;
  assign ld_pr  = PXR_W'(PIXEL_ROWS - 1) - ld_prc_r;
  assign ld_col = (ld_col_r == '0) ? '0 : COL_W'(PANEL_COLS) - ld_col_r;
  assign ld_s   = SA_W'(((ld_row * PANEL_COLS + ld_col) * QUARTER_ROWS + ld_qr)
                        * QUARTER_COLS + ld_qc_r);
  assign ld_pa  = PA_W'((ld_s * PIXEL_ROWS + ld_pr) * GRAY_BYTES + ld_b_r);

  assign rd_col = COL_W'(rd_reg_r * HALF_COLS + rd_rc_r);
  assign rd_s   = SA_W'(((rd_row_r * PANEL_COLS + rd_col) * QUARTER_ROWS + rd_qr_r)
                        * QUARTER_COLS + rd_qc_r);
  assign rd_pa  = PA_W'((rd_s * PIXEL_ROWS + rd_pr_r) * GRAY_BYTES + rd_b_r);

  assign str_addr = in_data.cmd ? rd_s : ld_s;
  assign pix_addr = in_data.cmd ? rd_pa : ld_pa;
  assign str_we   = ld_item && (ld_ph_r == PH_STR);
  assign pix_we   = ld_item && (ld_ph_r == PH_PIX);

  always_ff @(posedge clk) begin
    if (pix_we) begin
      pix_mem[pix_addr] <= in_data.pattern_byte;
    end
    pix_q_r <= pix_mem[pix_addr];
  end

  always_ff @(posedge clk) begin
    if (str_we) begin
      str_mem[str_addr] <= in_data.pattern_byte;
    end
    str_q_r <= str_mem[str_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gray_r      <= 1'b1;
      ld_mode_r   <= 1'b1;
      rd_mode_r   <= 1'b1;
      ld_pos_r    <= '0;
      rd_pos_r    <= '0;
      walk_r      <= '0;
      ld_ph_r     <= PH_SIG;
      ld_col_r    <= '0;
      ld_b_r      <= '0;
      ld_prc_r    <= '0;
      ld_qrc_r    <= '0;
      ld_qc_r     <= '0;
      ld_rowc_r   <= '0;
      rd_pix_r    <= 1'b0;
      rd_b_r      <= '0;
      rd_pr_r     <= '0;
      rd_qr_r     <= '0;
      rd_qc_r     <= '0;
      rd_reg_r    <= 1'b0;
      rd_row_r    <= '0;
      rd_rc_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        gray_r <= cfg_wdata;
      end
      out_valid_r <= cmd.accept;

      if (cmd.ld_clr || cmd.rd_clr) begin
        walk_r <= '0;
      end else if (cmd.ld_walk || cmd.rd_walk) begin
        walk_r <= walk_r + POS_W'(1);
      end

      // load pass digits
      if (cmd.ld_clr) begin
        if (ld_pos_r >= ld_len) begin
          ld_pos_r <= '0;
        end
        ld_ph_r   <= PH_SIG;
        ld_col_r  <= '0;
        ld_b_r    <= '0;
        ld_prc_r  <= '0;
        ld_qrc_r  <= '0;
        ld_qc_r   <= '0;
        ld_rowc_r <= '0;
      end else if (ld_item || cmd.ld_walk) begin
        if (ld_item) begin
          ld_pos_r <= ld_last ? '0 : ld_pos_inc;
        end
        ld_ph_r   <= ld_ph_nxt;
        ld_col_r  <= ld_col_nxt;
        ld_b_r    <= ld_b_nxt;
        ld_prc_r  <= ld_prc_nxt;
        ld_qrc_r  <= ld_qrc_nxt;
        ld_qc_r   <= ld_qc_nxt;
        ld_rowc_r <= ld_rowc_nxt;
      end
      if (cmd.ld_sync) begin
        ld_mode_r <= gray_r;
      end

      // readout pass digits
      if (cmd.rd_clr) begin
        if (rd_pos_r >= rd_len) begin
          rd_pos_r <= '0;
        end
        rd_pix_r <= 1'b0;
        rd_b_r   <= '0;
        rd_pr_r  <= '0;
        rd_qr_r  <= '0;
        rd_qc_r  <= '0;
        rd_reg_r <= 1'b0;
        rd_row_r <= '0;
        rd_rc_r  <= '0;
      end else if (rd_item || cmd.rd_walk) begin
        if (rd_item) begin
          rd_pos_r <= rd_last ? '0 : rd_pos_inc;
        end
        rd_pix_r <= rd_pix_nxt;
        rd_b_r   <= rd_b_nxt;
        rd_pr_r  <= rd_pr_nxt;
        rd_qr_r  <= rd_qr_nxt;
        rd_qc_r  <= rd_qc_nxt;
        rd_reg_r <= rd_reg_nxt;
        rd_row_r <= rd_row_nxt;
        rd_rc_r  <= rd_rc_nxt;
      end
      if (cmd.rd_sync) begin
        rd_mode_r <= gray_r;
      end
    end
  end

  // result word fields, shown the cycle after the store access
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      out_rd_r   <= in_data.cmd;
      out_str_r  <= !rd_pix_r;
      out_pos_r  <= in_data.cmd ? rd_pos_r : ld_pos_r;
      out_last_r <= in_data.cmd ? rd_last : ld_last;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_data.out_byte      = !out_rd_r ? 8'd0 : (out_str_r ? str_q_r : pix_q_r);
  assign out_data.pass_position = POSITION_W'(out_pos_r);
  assign out_data.pass_last     = out_last_r;

endmodule

@@ rtl/led_panel_frame_reorder.sv @@
// channel   ports                        handshake
// input     in_data (cmd, pattern_byte)  taken when start high and busy low
// result    out_data (out_byte,          out_valid high for one cycle,
//           pass_position, pass_last)    no backpressure
// config    cfg_we, cfg_wdata            gray_mode written when cfg_we high
//
// one word per cycle while busy is low: each accepted word does one frame store
// access and its result appears on the cycle after acceptance, while the next
// word is taken. after gray_mode changes, busy stays high while the load and
// readout digit counters are recounted to their saved positions, done before
// the next word.
// reset (rst_n low, synchronous) clears positions and sets gray_mode to 1;
// the frame store is not cleared. the receiver cannot stall results.
module led_panel_frame_reorder (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  lpfr_pkg::lpfr_in_t   in_data,
  output logic                 out_valid,
  output lpfr_pkg::lpfr_out_t  out_data,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata
);
  import lpfr_pkg::*;

  lpfr_cmd_t  cmd;
  lpfr_stat_t stat;

  lpfr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  lpfr_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
